// ===== rtl/core/lscs_pkg.sv =====
`timescale 1ns / 1ps
package lscs_pkg;

  // Geometry
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 4;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FILL_W       = $clog2(MAX_WAYS + 1);

  // Field widths
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int AGE_W      = 2;
  localparam int CNT_W      = 32;
  localparam int OUTCOME_W  = 2;
  localparam int SBITS_W    = 3;
  localparam int OBITS_W    = 5;
  localparam int WAYS_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [AGE_W-1:0] AGE_OLDEST = '1;

  // Command codes; the unused code behaves as a load
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HIT   = 2'd0,
    OC_FILL  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_t;

  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][AGE_W-1:0] age_row_t;
  typedef logic [MAX_WAYS-1:0]            valid_row_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch set index and tag of a new item
    logic look;     // read the set's tag and age rows
    logic commit;   // resolve the access and write the set back
  } dp_cmd_t;

endpackage

// ===== rtl/core/lru_set_assoc_cache_sim.sv =====
`timescale 1ns / 1ps
// Set-associative cache model with LRU replacement: 2^MAX_SET_BITS sets of
// MAX_WAYS lines. Each item (load, store, modify) looks up a 32-bit byte
// address split into offset / set / tag by the set_index_bits and
// offset_bits registers, and returns one result per access (hit, miss into a
// free way, or miss with eviction of the least recent line) together with
// saturating hit, miss and eviction totals. A modify makes two accesses and
// returns two results; only the second has last set. Each access goes
// through capture, a set row read from the tag/age memories, then compare
// and write-back; the second access of a modify skips the capture, and the
// write-back waits while the result register is held by out_stall. One item
// is in flight at a time; in_stall is low only while the block is idle, and a
// new item may be taken while the previous result still waits in the output
// register. Valid bits live in flops and are cleared by reset; tags and ages
// need no clearing. Register writes are always accepted (cfg_ready is tied
// high) and must only happen while the block is idle; they do not flush.
module lru_set_assoc_cache_sim
  import lscs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [ADDR_W-1:0]     addr,
  // Results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUTCOME_W-1:0]  outcome,
  output logic                  last,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      evict_total,
  // Register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t dp_cmd;

  assign cfg_ready = 1'b1;

  lscs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .last      (last),
    .dp_cmd    (dp_cmd)
  );

  lscs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .addr        (addr),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outcome     (outcome),
    .hit_total   (hit_total),
    .miss_total  (miss_total),
    .evict_total (evict_total)
  );

endmodule

// ===== rtl/core/lscs_dp.sv =====
`timescale 1ns / 1ps
module lscs_dp
  import lscs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               dp_cmd,
  input  logic [ADDR_W-1:0]     addr,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUTCOME_W-1:0]  outcome,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      evict_total
);

  // Config
  logic [SBITS_W-1:0] set_bits_q;
  logic [OBITS_W-1:0] off_bits_q;
  logic [WAYS_W-1:0]  ways_q;

  // Storage
  tag_row_t   tag_mem [NUM_SETS];
  age_row_t   age_mem [NUM_SETS];
  valid_row_t valid_q [NUM_SETS];

  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  tag_row_t         rd_tags;
  age_row_t         rd_ages;
  outcome_t         outcome_q;

  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;

  // Address split
  logic [SBITS_W-1:0] sbits;
  logic [OBITS_W:0]   total;
  logic [ADDR_W-1:0]  shifted;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   set_next;
  logic [TAG_W-1:0]   tag_next;

  always_comb begin
    sbits    = (32'(set_bits_q) > MAX_SET_BITS) ? SBITS_W'(MAX_SET_BITS) : set_bits_q;
    shifted  = addr >> off_bits_q;
    set_mask = SET_W'(((SET_W+1)'(1) << sbits) - (SET_W+1)'(1));
    set_next = shifted[SET_W-1:0] & set_mask;
    total    = (OBITS_W+1)'(off_bits_q) + (OBITS_W+1)'(sbits);
    tag_next = (total >= (OBITS_W+1)'(ADDR_W)) ? '0 : TAG_W'(addr >> total);
  end

  // Access resolution
  valid_row_t        vrow;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic              has_free;
  logic [WAY_W-1:0]  free_way;
  logic              has_vic;
  logic [WAY_W-1:0]  vic_way;
  logic [AGE_W-1:0]  oldest;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] limit;
  logic [WAY_W-1:0]  wr_way;
  outcome_t          oc;
  tag_row_t          new_tags;
  age_row_t          new_ages;

  always_comb begin
    vrow     = valid_q[set_q];
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    has_vic  = 1'b0;
    vic_way  = '0;
    oldest   = '0;
    fill     = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (vrow[w]) begin
        fill = fill + FILL_W'(1);
        if (!hit && rd_tags[w] == tag_q) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!has_vic || rd_ages[w] > oldest) begin
          has_vic = 1'b1;
          vic_way = WAY_W'(w);
          oldest  = rd_ages[w];
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end

    if (ways_q == '0) begin
      limit = FILL_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      limit = FILL_W'(MAX_WAYS);
    end else begin
      limit = FILL_W'(ways_q);
    end

    new_tags = rd_tags;
    new_ages = rd_ages;
    priority if (hit) begin
      oc     = OC_HIT;
      wr_way = hit_way;
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (vrow[w] && rd_ages[w] < rd_ages[hit_way]) begin
          new_ages[w] = rd_ages[w] + AGE_W'(1);
        end
      end
    end else if (fill < limit && has_free) begin
      oc     = OC_FILL;
      wr_way = free_way;
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (vrow[w] && rd_ages[w] != AGE_OLDEST) begin
          new_ages[w] = rd_ages[w] + AGE_W'(1);
        end
      end
    end else begin
      oc     = OC_EVICT;
      wr_way = vic_way;  // a full set always holds a valid line
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (WAY_W'(w) != vic_way && vrow[w] && rd_ages[w] != AGE_OLDEST) begin
          new_ages[w] = rd_ages[w] + AGE_W'(1);
        end
      end
    end
    new_tags[wr_way] = tag_q;
    new_ages[wr_way] = '0;
  end

  // Row memories
  always_ff @(posedge clk) begin
    if (dp_cmd.look) begin
      rd_tags <= tag_mem[set_q];
      rd_ages <= age_mem[set_q];
    end
    if (dp_cmd.commit) begin
      tag_mem[set_q] <= new_tags;
      age_mem[set_q] <= new_ages;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      set_q <= set_next;
      tag_q <= tag_next;
    end
    if (dp_cmd.commit) begin
      outcome_q <= oc;
    end
  end

  // Valid bits, counters, config
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
      hit_cnt    <= '0;
      miss_cnt   <= '0;
      evict_cnt  <= '0;
      set_bits_q <= SBITS_W'(1);
      off_bits_q <= OBITS_W'(1);
      ways_q     <= WAYS_W'(1);
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_SET_BITS: set_bits_q <= cfg_data[SBITS_W-1:0];
          CFG_OFF_BITS: off_bits_q <= cfg_data[OBITS_W-1:0];
          CFG_WAYS:     ways_q     <= cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (dp_cmd.commit) begin
        valid_q[set_q][wr_way] <= 1'b1;
        unique case (oc)
          OC_HIT: begin
            if (hit_cnt != '1) hit_cnt <= hit_cnt + CNT_W'(1);
          end
          OC_FILL: begin
            if (miss_cnt != '1) miss_cnt <= miss_cnt + CNT_W'(1);
          end
          OC_EVICT: begin
            if (miss_cnt != '1) miss_cnt <= miss_cnt + CNT_W'(1);
            if (evict_cnt != '1) evict_cnt <= evict_cnt + CNT_W'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // Counters only move on commit, which waits for the output slot
  assign outcome     = outcome_q;
  assign hit_total   = hit_cnt;
  assign miss_total  = miss_cnt;
  assign evict_total = evict_cnt;

endmodule

// ===== rtl/core/lscs_ctrl.sv =====
`timescale 1ns / 1ps
module lscs_ctrl
  import lscs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] cmd,
  input  logic             out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output logic             last,
  output dp_cmd_t          dp_cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state;
  logic   mod_pend;  // first pass of a modify in flight
  logic   out_free;

  assign in_stall = rst || (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    dp_cmd.capture = in_valid && !in_stall;
    dp_cmd.look    = (state == ST_READ);
    dp_cmd.commit  = (state == ST_UPDATE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mod_pend  <= 1'b0;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      if (dp_cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (dp_cmd.capture) begin
            mod_pend <= (cmd == CMD_MODIFY);
            state    <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (dp_cmd.commit) begin
            last     <= !mod_pend;
            mod_pend <= 1'b0;
            state    <= mod_pend ? ST_READ : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/lscs_checker.sv =====
`timescale 1ns / 1ps
module lscs_checker
  import lscs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [OUTCOME_W-1:0]  outcome,
  input logic                  last,
  input logic [CNT_W-1:0]      hit_total,
  input logic [CNT_W-1:0]      miss_total,
  input logic [CNT_W-1:0]      evict_total
);

  // One item in flight: an accepted item blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in flight");

  // Hit total never drops outside reset
  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst)) |-> (hit_total >= $past(hit_total)))
    else $error("hit total decreased");

  // A shown result is already counted
  a_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((outcome == OC_HIT && hit_total != '0) ||
                   (outcome == OC_FILL && miss_total != '0) ||
                   (outcome == OC_EVICT && miss_total != '0 && evict_total != '0)))
    else $error("result outcome not reflected in totals");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(outcome) && $stable(last)
                                  && $stable(hit_total)))
    else $error("stalled result changed");

endmodule

bind lru_set_assoc_cache_sim lscs_checker u_lscs_checker (.*);
